@@ src/q4dq_pkg.sv @@
// ----------------------------------------------------------------------------
// q4dq_pkg: shared types and constants for the 4-bit block dequantizer.
// Holds the item payload types, panel geometry and the value converter.
// ----------------------------------------------------------------------------
package q4dq_pkg;

   localparam int PANEL_ROWS = 16;
   localparam int BLOCK_LEN  = 32;
   localparam int HALF_BYTES = BLOCK_LEN / 2;
   localparam int BYTE_W     = $clog2(HALF_BYTES);
   localparam int IDX_W      = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] QNAN_VALUE = 32'h7FC00000;
   localparam logic [3:0]  NIB_BIAS   = 4'd8;

   typedef struct packed {
      logic [15:0] scale_half;
      logic [63:0] quants_low;
      logic [63:0] quants_high;
      logic [3:0]  row;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] low_index;
      logic [31:0]      low_value;
      logic [IDX_W-1:0] high_index;
      logic [31:0]      high_value;
      logic             last;
   } rsp_type;

   // Pre-decoded scale, produced by the front end for each accepted block.
   typedef struct packed {
      logic        sign;
      logic        is_special;  // exponent all ones
      logic        is_nan;
      logic [10:0] man;         // significand with hidden bit when normal
      logic [5:0]  ex_bias;     // exponent of product LSB plus 127, minus 100
      logic [9:0]  frac;
   } scale_type;

   typedef struct packed {
      scale_type   scale;
      logic [127:0] quants;
      logic [3:0]  row;
   } block_type;

   // Scale times (nibble - 8) as single-precision bits. Product is at most
   // 15 bits, so the leading-one search covers few positions.
   function automatic logic [31:0] scaled_value(scale_type sc, logic [3:0] nib);
      logic        neg;
      logic [3:0]  mag;
      logic [14:0] prod;
      logic [3:0]  p;
      logic [7:0]  fexp;
      logic [22:0] mant;
      logic [31:0] res;
      neg  = (nib < NIB_BIAS);
      mag  = neg ? (NIB_BIAS - nib) : (nib - NIB_BIAS);
      prod = sc.man * mag;
      p    = 4'd0;
      for (int b = 1; b < 15; b++) begin
         if (prod[b]) p = 4'(b);
      end
      fexp = 8'(sc.ex_bias) + 8'd100 + 8'(p);
      mant = 23'({8'd0, prod} << (5'd23 - 5'(p)));
      if (sc.is_special) begin
         // The payload lands at the top of the mantissa under the quiet bit.
         if (sc.is_nan) res = {sc.sign, 8'hFF, 1'b1, sc.frac[8:0], 13'd0};
         else if (mag == 4'd0) res = QNAN_VALUE;
         else res = {sc.sign ^ neg, 8'hFF, 23'd0};
      end else if (prod == 15'd0) begin
         res = {sc.sign ^ neg, 31'd0};
      end else begin
         res = {sc.sign ^ neg, fexp, mant};
      end
      return res;
   endfunction

endpackage

@@ src/q4dq_if.sv @@
// ----------------------------------------------------------------------------
// q4dq_if: valid/ready channel carrying one payload.
// Generic handshake interface used for the request and response channels.
// ----------------------------------------------------------------------------
interface q4dq_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/q4dq_front.sv @@
// ----------------------------------------------------------------------------
// q4dq_front: accepts blocks, decodes the scale and fills a short queue.
// Two-entry queue decouples intake from the per-byte back end.
// ----------------------------------------------------------------------------
module q4dq_front
   import q4dq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   q4dq_if.sink      req,
   output block_type head,
   output logic      head_valid,
   input  logic      head_pop
);

   block_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]       count_ff;
   logic                  push;
   block_type             decoded;
   logic [4:0]            e;

   // Scale classification.
   always_comb begin
      e = req.payload.scale_half[14:10];
      decoded.scale.sign       = req.payload.scale_half[15];
      decoded.scale.is_special = (e == 5'h1F);
      decoded.scale.is_nan     = (e == 5'h1F) && (req.payload.scale_half[9:0] != 10'd0);
      decoded.scale.frac       = req.payload.scale_half[9:0];
      decoded.scale.man        = {(e != 5'd0), req.payload.scale_half[9:0]};
      // exponent of LSB: -24 for subnormal, e-25 otherwise; plus 127 minus 100
      decoded.scale.ex_bias    = (e == 5'd0) ? 6'd3 : 6'(e) + 6'd2;
      decoded.quants           = {req.payload.quants_high, req.payload.quants_low};
      decoded.row              = req.payload.row;
   end

   assign req.ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= decoded;
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (head_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(head_pop);
      end
   end

endmodule

@@ src/q4dq_back.sv @@
// ----------------------------------------------------------------------------
// q4dq_back: walks the head block's sixteen bytes, one per cycle unless stalled.
// Converts both nibbles and registers the result in an output stage.
// ----------------------------------------------------------------------------
module q4dq_back
   import q4dq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  block_type head,
   input  logic      head_valid,
   output logic      head_pop,
   q4dq_if.source    rsp
);

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff;
   rsp_type           result;
   logic              advance;
   logic [7:0]        cur_byte;

   // The output stage takes a new result when empty or being drained.
   assign advance  = head_valid && (!out_valid_ff || rsp.ready);
   assign head_pop = advance && (byte_ff == BYTE_W'(HALF_BYTES - 1));
   assign cur_byte = head.quants[{byte_ff, 3'b000} +: 8];

   // Result formation for the current byte.
   always_comb begin
      result.low_index  = IDX_W'(int'(byte_ff) * PANEL_ROWS + int'(head.row));
      result.high_index = IDX_W'((int'(byte_ff) + HALF_BYTES) * PANEL_ROWS
                                 + int'(head.row));
      result.low_value  = scaled_value(head.scale, cur_byte[3:0]);
      result.high_value = scaled_value(head.scale, cur_byte[7:4]);
      result.last       = (byte_ff == BYTE_W'(HALF_BYTES - 1));
   end

   always_comb begin
      byte_in      = advance ? byte_ff + 1'b1 : byte_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   // Byte counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         byte_ff      <= byte_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (advance) out_ff <= result;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

endmodule

@@ src/q4_block_dequant_transpose.sv @@
// ----------------------------------------------------------------------------
// q4_block_dequant_transpose: 4-bit block dequantizer with panel transpose.
// Expands one quantized block into sixteen results of two floats each.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | scale_half, quants_low, quants_high, row
//  rsp     | out       | low_index, low_value, high_index, high_value, last
//
// Each block yields sixteen results, one per cycle unless the output stalls;
// the byte walker in the back end sets this rate.
// A two-entry queue lets the next block be taken while one is being expanded.
// Reset is synchronous and clears queue pointers, counters and output valid only.
// A stalled result holds in the output register; the walker waits with it.
module q4_block_dequant_transpose
   import q4dq_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   q4dq_if.sink   req,
   q4dq_if.source rsp
);

   block_type head;
   logic      head_valid;
   logic      head_pop;

   q4dq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   q4dq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp        (rsp)
   );

endmodule

@@ tb/q4dq_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_tb_if: notes for the dequantizer testbench.
// The channel interface comes with the RTL; this file holds the shared
// testbench types used by the top module.
// ----------------------------------------------------------------------------
package q4dq_tb_pkg;
   import q4dq_pkg::*;

   // One row of the directed stimulus table.
   typedef struct {
      req_type     blk;
      bit          known;       // expected value typed in below
      logic [31:0] low_val;     // value for every low nibble when known
      logic [31:0] high_val;    // value for every high nibble when known
   } dir_row_type;
endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for q4_block_dequant_transpose.
// Drives quantized blocks through valid/ready, predicts the sixteen results
// of each block with an independent half-to-single model or typed-in values,
// checks every result in order, with random stalls and a receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import q4dq_pkg::*;
   import q4dq_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   bit   failed = 1'b0;

   q4dq_if #(.payload_type(req_type)) req (clock);
   q4dq_if #(.payload_type(rsp_type)) rsp (clock);

   q4_block_dequant_transpose dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   rsp_type expected_rsps[$];
   int      send_idle_pct = 15;
   int      recv_idle_pct = 58;
   bit      hold_req = 1'b0;
   bit      hold_done = 1'b0;
   int      hold_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Dequantized value of one nibble: half scale times (nibble - 8), exact.
   function automatic logic [31:0] dequant_value(logic [15:0] h, logic [3:0] nib);
      logic        s, neg;
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  mag;
      logic [31:0] man, prod;
      int          lsb_exp, p;
      s = h[15];
      e = h[14:10];
      m = h[9:0];
      neg = nib < 4'd8;
      mag = neg ? 4'd8 - nib : nib - 4'd8;
      if (e == 5'h1F) begin
         if (m != 0) return {s, 8'hFF, 1'b1, m[8:0], 13'd0};
         if (mag == 0) return 32'h7FC00000;
         return {s ^ neg, 8'hFF, 23'd0};
      end
      man = (e == 0) ? {22'd0, m} : {21'd0, 1'b1, m};
      lsb_exp = (e == 0) ? -24 : int'(e) - 25;
      prod = man * mag;
      if (prod == 0) return {s ^ neg, 31'd0};
      p = 0;
      for (int b = 1; b < 32; b++) if (prod[b]) p = b;
      dequant_value = {s ^ neg, 8'(p + lsb_exp + 127), 23'((prod << (23 - p)))};
   endfunction

   // Queue the sixteen results of one block, optionally with typed-in values.
   task automatic queue_block_results(req_type blk, bit known, logic [31:0] lv,
                                      logic [31:0] hv);
      logic [127:0] q;
      logic [7:0]   b;
      rsp_type      r;
      q = {blk.quants_high, blk.quants_low};
      for (int i = 0; i < HALF_BYTES; i++) begin
         b = q[8*i +: 8];
         r.low_index  = IDX_W'(i * PANEL_ROWS + blk.row);
         r.high_index = IDX_W'((i + HALF_BYTES) * PANEL_ROWS + blk.row);
         r.low_value  = known ? lv : dequant_value(blk.scale_half, b[3:0]);
         r.high_value = known ? hv : dequant_value(blk.scale_half, b[7:4]);
         r.last       = (i == HALF_BYTES - 1);
         expected_rsps.push_back(r);
      end
   endtask

   // Offer one block and wait for its transfer. Valid stays high afterwards
   // so that blocks can follow back to back; idling drops it.
   task automatic send_block(req_type blk, bit known = 0, logic [31:0] lv = 0,
                             logic [31:0] hv = 0);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= blk;
      do @(posedge clock); while (!req.ready);
      queue_block_results(blk, known, lv, hv);
   endtask

   function automatic req_type random_block();
      req_type blk;
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(9))
         0: h[14:10] = 5'h00;
         1: h[14:10] = 5'h1F;
         2: h[14:0] = 15'd0;
         default: ;
      endcase
      blk.scale_half  = h;
      blk.quants_low  = {$urandom, $urandom};
      blk.quants_high = {$urandom, $urandom};
      blk.row         = 4'($urandom);
      return blk;
   endfunction

   // Receiver readiness: random idling, or a long counted hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         hold_count <= 0;
      end else if (hold_req && !hold_done) begin
         hold_done  <= 1'b1;
         hold_count <= 300;
         rsp.ready  <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker: every transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp.payload);
            failed = 1'b1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.payload.low_index !== e.low_index)
               $display("%0t: low_index expected %h actual %h", $time,
                        e.low_index, rsp.payload.low_index);
            if (rsp.payload.low_value !== e.low_value)
               $display("%0t: low_value expected %h actual %h", $time,
                        e.low_value, rsp.payload.low_value);
            if (rsp.payload.high_index !== e.high_index)
               $display("%0t: high_index expected %h actual %h", $time,
                        e.high_index, rsp.payload.high_index);
            if (rsp.payload.high_value !== e.high_value)
               $display("%0t: high_value expected %h actual %h", $time,
                        e.high_value, rsp.payload.high_value);
            if (rsp.payload.last !== e.last)
               $display("%0t: last expected %b actual %b", $time,
                        e.last, rsp.payload.last);
            if (rsp.payload !== e) failed = 1'b1;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("q4_block_dequant_transpose test failed");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      dir_row_type d;
      req.valid   = 1'b0;
      req.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: uniform nibbles give values readable at a glance.
      d.blk = '{16'h3C00, 64'h0000000000000000, 64'h0, 4'd0};
      d.known = 1; d.low_val = 32'hC1000000; d.high_val = 32'hC1000000;
      dir_rows.push_back(d);
      d.blk = '{16'h3C00, {8{8'hF8}}, {8{8'hF8}}, 4'd15};
      d.known = 1; d.low_val = 32'h00000000; d.high_val = 32'h40E00000;
      dir_rows.push_back(d);
      d.blk = '{16'hBC00, {8{8'h08}}, {8{8'h08}}, 4'd7};
      d.known = 1; d.low_val = 32'h80000000; d.high_val = 32'h41000000;
      dir_rows.push_back(d);
      // Infinite scale: nibble 8 gives the quiet NaN.
      d.blk = '{16'h7C00, {8{8'h08}}, {8{8'h08}}, 4'd3};
      d.known = 1; d.low_val = 32'h7FC00000; d.high_val = 32'hFF800000;
      dir_rows.push_back(d);
      d.blk = '{16'hFC00, {8{8'h9F}}, {8{8'h9F}}, 4'd9};
      d.known = 1; d.low_val = 32'hFF800000; d.high_val = 32'hFF800000;
      dir_rows.push_back(d);
      // NaN scale keeps its sign and payload for every nibble.
      d.blk = '{16'hFE01, {8{8'h5A}}, {8{8'h5A}}, 4'd1};
      d.known = 1; d.low_val = 32'hFFC02000; d.high_val = 32'hFFC02000;
      dir_rows.push_back(d);
      d.blk = '{16'h7C01, {8{8'h00}}, {8{8'h00}}, 4'd2};
      d.known = 1; d.low_val = 32'h7FC02000; d.high_val = 32'h7FC02000;
      dir_rows.push_back(d);
      // Zero scale, signed.
      d.blk = '{16'h8000, {8{8'h0F}}, {8{8'h0F}}, 4'd4};
      d.known = 1; d.low_val = 32'h80000000; d.high_val = 32'h00000000;
      dir_rows.push_back(d);
      // Rows checked by the predictor: subnormals, largest finite, mixed.
      d.known = 0;
      d.blk = '{16'h0001, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 4'd5};
      dir_rows.push_back(d);
      d.blk = '{16'h03FF, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 4'd14};
      dir_rows.push_back(d);
      d.blk = '{16'h8001, 64'h0F1E2D3C4B5A6978, 64'h8796A5B4C3D2E1F0, 4'd6};
      dir_rows.push_back(d);
      d.blk = '{16'h7BFF, 64'h0123456789ABCDEF, 64'h0123456789ABCDEF, 4'd11};
      dir_rows.push_back(d);
      d.blk = '{16'hFBFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd12};
      dir_rows.push_back(d);
      d.blk = '{16'h0400, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 4'd13};
      dir_rows.push_back(d);
      foreach (dir_rows[i])
         send_block(dir_rows[i].blk, dir_rows[i].known, dir_rows[i].low_val,
                    dir_rows[i].high_val);

      // The sender pauses until every expected result has come.
      req.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);

      // Long receiver hold-off while the sender keeps offering blocks.
      hold_req = 1'b1;
      send_idle_pct = 0;
      repeat (6) send_block(random_block());

      // Random phases with changing idle rates.
      for (int n = 0; n < 390; n++) begin
         if (n == 130) begin
            send_idle_pct = 58; recv_idle_pct = 15;
         end else if (n == 260) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (n == 6) begin
            send_idle_pct = 15;
         end
         send_block(random_block());
      end

      req.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (!failed && expected_rsps.size() == 0) begin
         $display("q4_block_dequant_transpose test passed");
      end else begin
         $display("q4_block_dequant_transpose test failed");
      end
      $finish;
   end
endmodule
